@@ sv/hpbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hpbp_pkg: shared definitions for the HDR pixel to BGR byte packer
// Field widths, the side limit and the structs that join the submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package hpbp_pkg;

    localparam int CHAN_W  = 24;              // channel magnitude and weight width
    localparam int IN_W    = CHAN_W + 1;      // signed Q8.16 channel input
    localparam int BYTE_W  = 8;
    localparam int PROD_W  = CHAN_W + BYTE_W; // channel times 255
    localparam int SIDE_W  = 13;              // width/height register width
    localparam int COUNT_W = 12;              // row and column counters
    localparam int MAX_SIDE = 4096;
    localparam int LEFT_W  = 3;               // up to six bytes per pixel

    localparam logic [SIDE_W-1:0] MAX_SIDE_C  = SIDE_W'(MAX_SIDE);
    localparam logic [CHAN_W-1:0] UNIT_WEIGHT = CHAN_W'(65536);
    localparam logic [BYTE_W-1:0] BYTE_FULL   = {BYTE_W{1'b1}};

    typedef struct packed {
        logic              start;
        logic [CHAN_W-1:0] dividend;
        logic [CHAN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] quot;
    } div_rsp_t;

    // One finished pixel: blue in the low byte, then green, then red.
    typedef struct packed {
        logic                valid;
        logic [3*BYTE_W-1:0] bgr;
    } load_t;

endpackage

`default_nettype wire

@@ sv/hpbp_div.sv @@
// ----------------------------------------------------------------------------
// hpbp_div: bit-serial saturating channel divider
// Computes min(floor(c*255/w), 255), one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hpbp_div (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  hpbp_pkg::div_req_t  req,
    output hpbp_pkg::div_rsp_t  rsp
);
    import hpbp_pkg::*;

    localparam logic [1:0] DIV_IDLE = 2'd0;
    localparam logic [1:0] DIV_SAT  = 2'd1;
    localparam logic [1:0] DIV_STEP = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [CHAN_W-1:0] w_reg, w_next;
    logic [CHAN_W-1:0] rem_reg, rem_next;
    logic [BYTE_W-1:0] dig_reg, dig_next;
    logic [LEFT_W-1:0] cnt_reg, cnt_next;

    logic [CHAN_W:0]   rem_sh;
    logic [CHAN_W:0]   rem_sub;
    logic              rem_ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign rem_sh  = {rem_reg, dig_reg[BYTE_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, w_reg};
    assign rem_sub = rem_sh - {1'b0, w_reg};

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        w_next     = w_reg;
        rem_next   = rem_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            DIV_IDLE: begin
                if (req.start) begin
                    prod_next  = {req.dividend, {BYTE_W{1'b0}}}
                               - {{BYTE_W{1'b0}}, req.dividend};
                    w_next     = req.divisor;
                    state_next = DIV_SAT;
                end
            end
            DIV_SAT: begin
                // The quotient reaches 256 exactly when the high part alone
                // already covers the divisor; a zero divisor lands here too.
                if (prod_reg[PROD_W-1:BYTE_W] >= w_reg) begin
                    dig_next   = BYTE_FULL;
                    done_next  = 1'b1;
                    state_next = DIV_IDLE;
                end else begin
                    rem_next   = prod_reg[PROD_W-1:BYTE_W];
                    dig_next   = prod_reg[BYTE_W-1:0];
                    cnt_next   = '0;
                    state_next = DIV_STEP;
                end
            end
            DIV_STEP: begin
                rem_next = rem_ge ? rem_sub[CHAN_W-1:0] : rem_sh[CHAN_W-1:0];
                dig_next = {dig_reg[BYTE_W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LEFT_W'(BYTE_W - 1)) begin
                    done_next  = 1'b1;
                    state_next = DIV_IDLE;
                end
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        prod_reg <= prod_next;
        w_reg    <= w_next;
        rem_reg  <= rem_next;
        dig_reg  <= dig_next;
        cnt_reg  <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dig_reg;

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == DIV_STEP) |-> (rem_reg < w_reg))
        else $error("partial remainder not below divisor");

    a_done_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (state_reg == DIV_IDLE))
        else $error("divider busy while reporting a quotient");

endmodule

`default_nettype wire

@@ sv/hpbp_emit.sv @@
// ----------------------------------------------------------------------------
// hpbp_emit: byte shifter with row padding and row/column tracking
// Shifts a pixel's three bytes out, then the padding zeros of a row end.
// ----------------------------------------------------------------------------
`default_nettype none

module hpbp_emit (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  [hpbp_pkg::SIDE_W-1:0]  image_width,
    input  wire  [hpbp_pkg::SIDE_W-1:0]  image_height,
    input  hpbp_pkg::load_t              load,
    output logic                         load_ready,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [hpbp_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                         m_is_padding,
    output logic                         m_last,
    output logic                         m_image_end
);
    import hpbp_pkg::*;

    logic [3*BYTE_W-1:0] sh_reg, sh_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [1:0]          pad_reg, pad_next;
    logic                end_reg, end_next;
    logic [COUNT_W-1:0]  col_reg, col_next;
    logic [COUNT_W-1:0]  row_reg, row_next;

    logic [SIDE_W-1:0]   wid, hgt;
    logic                row_end, img_end;
    logic [1:0]          pad;
    logic                load_fire, out_fire;

    always_comb begin
        if (image_width == '0) begin
            wid = SIDE_W'(1);
        end else if (image_width > MAX_SIDE_C) begin
            wid = MAX_SIDE_C;
        end else begin
            wid = image_width;
        end
        if (image_height == '0) begin
            hgt = SIDE_W'(1);
        end else if (image_height > MAX_SIDE_C) begin
            hgt = MAX_SIDE_C;
        end else begin
            hgt = image_height;
        end
    end

    assign row_end = ({1'b0, col_reg} + 1'b1) >= wid;
    assign img_end = ({1'b0, row_reg} + 1'b1) >= hgt;
    // Three bytes per pixel: the padding to a multiple of four equals width mod 4.
    assign pad     = row_end ? wid[1:0] : 2'd0;

    assign m_valid    = left_reg != '0;
    assign out_fire   = m_valid && m_ready;
    assign load_ready = (left_reg == '0) || ((left_reg == LEFT_W'(1)) && m_ready);
    assign load_fire  = load.valid && load_ready;

    always_comb begin
        sh_next   = sh_reg;
        left_next = left_reg;
        pad_next  = pad_reg;
        end_next  = end_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (load_fire) begin
            sh_next   = load.bgr;
            left_next = LEFT_W'(3) + {1'b0, pad};
            pad_next  = pad;
            end_next  = row_end && img_end;
            if (row_end) begin
                col_next = '0;
                row_next = img_end ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end else if (out_fire) begin
            sh_next   = {{BYTE_W{1'b0}}, sh_reg[3*BYTE_W-1:BYTE_W]};
            left_next = left_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            left_reg <= left_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
        sh_reg  <= sh_next;
        pad_reg <= pad_next;
        end_reg <= end_next;
    end

    assign m_out_byte   = sh_reg[BYTE_W-1:0];
    assign m_is_padding = m_valid && ({1'b0, pad_reg} >= left_reg);
    assign m_last       = left_reg == LEFT_W'(1);
    assign m_image_end  = m_last && end_reg;

    a_pad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_padding) |-> (m_out_byte == '0))
        else $error("padding word carries a nonzero byte");

    a_load_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        load_fire |=> (left_reg >= LEFT_W'(3)))
        else $error("pixel loaded with fewer than three bytes");

    a_end_clears_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_image_end) |-> ((col_reg == '0) && (row_reg == '0)))
        else $error("counters not cleared at the end of the image");

endmodule

`default_nettype wire

@@ sv/hdr_pixel_to_bgr_packer.sv @@
// ----------------------------------------------------------------------------
// hdr_pixel_to_bgr_packer: HDR pixel to 24-bit BGR scanline packer
// Normalizes accumulated pixels by their weight, or by unit weight when weighting is off, and emits padded BGR bytes.
// ----------------------------------------------------------------------------
// The blue, green and red channels pass one after another through a single
// bit-serial divider, producing one quotient bit per cycle. A channel whose
// quotient saturates at 255 (a zero weight included) skips the bit steps. The
// three bytes go to the output shifter once all three channels are divided,
// and the input is ready again on the next cycle. A pixel with a negative
// channel skips the divider: its marker bytes go straight to ST_LOAD for the
// shifter, and the input is ready again after that hand-off. Each hand-off
// waits while the shifter still holds more than one byte of the previous
// pixel, or holds its last byte while m_ready is low. The bytes leave the
// shifter at up to one byte per cycle while m_ready is high, 3 to 6 per
// pixel, and the shifter drains while the next pixel is divided.
`default_nettype none

module hdr_pixel_to_bgr_packer (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  signed [hpbp_pkg::IN_W-1:0]    s_red,
    input  wire  signed [hpbp_pkg::IN_W-1:0]    s_green,
    input  wire  signed [hpbp_pkg::IN_W-1:0]    s_blue,
    input  wire         [hpbp_pkg::CHAN_W-1:0]  s_weight,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic        [hpbp_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                                m_is_padding,
    output logic                                m_last,
    output logic                                m_image_end,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire         [1:0]                   cfg_index,
    input  wire         [hpbp_pkg::SIDE_W-1:0]  cfg_data
);
    import hpbp_pkg::*;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_USE_W  = 2'd2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [SIDE_W-1:0]   width_reg, width_next;
    logic [SIDE_W-1:0]   height_reg, height_next;
    logic                use_w_reg, use_w_next;

    logic [1:0]          state_reg, state_next;
    logic [3*CHAN_W-1:0] chan_reg, chan_next;
    logic [CHAN_W-1:0]   w_reg, w_next;
    logic [3*BYTE_W-1:0] bgr_reg, bgr_next;
    logic [1:0]          ch_reg, ch_next;

    div_req_t            div_req;
    div_rsp_t            div_rsp;
    load_t               load;
    logic                load_ready;
    logic                in_fire, cfg_fire, neg;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        use_w_next  = use_w_reg;
        if (cfg_fire) begin
            case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data;
                REG_HEIGHT: height_next = cfg_data;
                REG_USE_W:  use_w_next  = cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign in_fire = s_valid && s_ready;
    assign neg     = s_red[IN_W-1] || s_green[IN_W-1] || s_blue[IN_W-1];

    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        w_next     = w_reg;
        bgr_next   = bgr_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    chan_next = {s_red[CHAN_W-1:0], s_green[CHAN_W-1:0],
                                 s_blue[CHAN_W-1:0]};
                    w_next    = use_w_reg ? s_weight : UNIT_WEIGHT;
                    ch_next   = '0;
                    if (neg) begin
                        // Marker color for a pixel with any negative channel.
                        bgr_next   = {BYTE_FULL, {BYTE_W{1'b0}}, {BYTE_W{1'b0}}};
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_rsp.done) begin
                    // Quotients enter at the top, so blue ends in the low byte.
                    bgr_next  = {div_rsp.quot, bgr_reg[3*BYTE_W-1:BYTE_W]};
                    chan_next = {{CHAN_W{1'b0}}, chan_reg[3*CHAN_W-1:CHAN_W]};
                    ch_next   = ch_reg + 1'b1;
                    state_next = (ch_reg == 2'd2) ? ST_LOAD : ST_START;
                end
            end
            ST_LOAD: begin
                if (load_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIDE_W'(640);
            height_reg <= SIDE_W'(480);
            use_w_reg  <= 1'b1;
            state_reg  <= ST_IDLE;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            use_w_reg  <= use_w_next;
            state_reg  <= state_next;
        end
        chan_reg <= chan_next;
        w_reg    <= w_next;
        bgr_reg  <= bgr_next;
        ch_reg   <= ch_next;
    end

    assign div_req.start    = state_reg == ST_START;
    assign div_req.dividend = chan_reg[CHAN_W-1:0];
    assign div_req.divisor  = w_reg;

    assign load.valid = state_reg == ST_LOAD;
    assign load.bgr   = bgr_reg;

    hpbp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    hpbp_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (width_reg),
        .image_height (height_reg),
        .load         (load),
        .load_ready   (load_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_is_padding (m_is_padding),
        .m_last       (m_last),
        .m_image_end  (m_image_end)
    );

    a_done_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_WAIT))
        else $error("divider result arrived outside the wait state");

endmodule

`default_nettype wire
